[design/rrs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrs_pkg: shared types and constants of the round-robin scheduler
// Holds the command and queue entry formats, the result status codes and
// the back-end state encoding.
// ----------------------------------------------------------------------------
package rrs_pkg;

  localparam int ID_W    = 16;
  localparam int BURST_W = 16;
  localparam int TIME_W  = 20;
  localparam int QUANT_W = 16;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_SLICE    = 2'd0,
    STATUS_ACCEPTED = 2'd1,
    STATUS_FULL     = 2'd2,
    STATUS_EMPTY    = 2'd3
  } status_t;

  // Classified command, as held in the command queue.
  typedef enum logic {
    OP_ADD      = 1'b0,
    OP_DISPATCH = 1'b1
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [ID_W-1:0]    job_id;
    logic [BURST_W-1:0] burst;
  } cmd_t;

  // One entry of the ready queue memory.
  typedef struct packed {
    logic [ID_W-1:0]    job;
    logic [BURST_W-1:0] remaining;
    logic [BURST_W-1:0] burst;
    logic [TIME_W-1:0]  first_start;
    logic               started;
  } entry_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_t;

endpackage : rrs_pkg
`default_nettype wire

[design/round_robin_time_slice_scheduler.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// round_robin_time_slice_scheduler: round-robin scheduler with a configurable quantum
// Input transfers either add a job to a FIFO ready queue of MAX_JOBS entries
// or dispatch one time slice of the head job; every transfer gives one result.
// ----------------------------------------------------------------------------
// An add completes in the idle state that accepts it. A dispatch reads the
// head entry in the idle state, since the ready queue memory has a registered
// read port, runs the slice and writes the job back to the tail in the
// execute state, and loads the result register in the response state. Full
// and empty results are loaded in the idle state. A two-entry command queue
// in front keeps input transfers flowing while the back end works or waits
// for the result to be taken; each item is registered in that queue. The
// quantum register may be written only while no item is in flight; a quantum
// of zero acts as one. Queue entries need no clearing after reset.
module round_robin_time_slice_scheduler #(
  parameter int MAX_JOBS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write,
  input  wire logic [rrs_pkg::QUANT_W-1:0] cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        func,
  input  wire logic [rrs_pkg::ID_W-1:0]    job_id,
  input  wire logic [rrs_pkg::BURST_W-1:0] burst_time,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output rrs_pkg::status_t                 status,
  output logic [rrs_pkg::ID_W-1:0]         slice_job,
  output logic [rrs_pkg::TIME_W-1:0]       slice_start,
  output logic [rrs_pkg::TIME_W-1:0]       slice_finish,
  output logic                             job_done,
  output logic [rrs_pkg::TIME_W-1:0]       response_time,
  output logic [rrs_pkg::TIME_W-1:0]       turnaround_time,
  output logic [rrs_pkg::TIME_W-1:0]       waiting_time
);
  import rrs_pkg::*;

  logic               quantum;
  logic [QUANT_W-1:0] quantum_reg;
  logic               cmd_valid;
  logic               cmd_ready;
  cmd_t               cmd;

  // Quantum configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum_reg <= QUANT_W'(4);
    end else if (cfg_write) begin
      quantum_reg <= cfg_data;
    end
  end

  assign quantum = (quantum_reg != '0);

  // Front end: take transfers and queue classified commands.
  rrs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .job_id     (job_id),
    .burst_time (burst_time),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd)
  );

  // Back end: ready queue, clock and results.
  rrs_back #(
    .MAX_JOBS (MAX_JOBS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cmd_valid       (cmd_valid),
    .cmd_ready       (cmd_ready),
    .cmd             (cmd),
    .quantum         (quantum_reg),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .slice_job       (slice_job),
    .slice_start     (slice_start),
    .slice_finish    (slice_finish),
    .job_done        (job_done),
    .response_time   (response_time),
    .turnaround_time (turnaround_time),
    .waiting_time    (waiting_time)
  );

  // A completed job reports its completion time as the slice finish.
  a_turnaround_is_finish : assert property (@(posedge clk) disable iff (rst)
    (out_valid && job_done) |-> (turnaround_time == slice_finish))
    else $error("turnaround differs from slice finish");

  // A slice never ends before it starts, whatever the saturation.
  a_finish_after_start : assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == STATUS_SLICE)) |-> (slice_finish >= slice_start))
    else $error("slice finishes before it starts");

  // Only a dispatched slice can complete a job.
  a_done_only_on_slice : assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != STATUS_SLICE)) |-> (!job_done && (slice_job == '0)))
    else $error("non-slice result carries slice fields");

  // Waiting time never exceeds turnaround, and a job first started no later
  // than its final slice.
  a_waiting_bounded : assert property (@(posedge clk) disable iff (rst)
    (out_valid && job_done) |-> ((waiting_time <= turnaround_time)
                                 && (response_time <= slice_start)))
    else $error("completion times inconsistent");

  // Reset loads a nonzero quantum.
  a_quantum_reset : assert property (@(posedge clk)
    $past(rst) |-> quantum)
    else $error("quantum not set by reset");

endmodule : round_robin_time_slice_scheduler
`default_nettype wire

[design/rrs_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrs_front: input side of the scheduler
// Takes input transfers, classifies them into add or dispatch commands and
// holds them in a two-entry queue until the back end is free.
// ----------------------------------------------------------------------------
module rrs_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        func,
  input  wire logic [rrs_pkg::ID_W-1:0]    job_id,
  input  wire logic [rrs_pkg::BURST_W-1:0] burst_time,
  output logic                             cmd_valid,
  input  wire logic                        cmd_ready,
  output rrs_pkg::cmd_t                    cmd
);
  import rrs_pkg::*;

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;
  cmd_t       in_cmd;

  // Classify the incoming item.
  always_comb begin
    in_cmd.op     = func ? OP_DISPATCH : OP_ADD;
    in_cmd.job_id = job_id;
    in_cmd.burst  = burst_time;
  end

  assign in_ready  = (fill != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (fill != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = slot[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_cmd;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule : rrs_front
`default_nettype wire

[design/rrs_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrs_back: execution side of the scheduler
// Owns the ready queue memory, the clock and the result register. Adds
// complete on acceptance; a dispatch reads the head entry, runs the slice
// and writes an unfinished job back to the tail, then forms the result.
// ----------------------------------------------------------------------------
module rrs_back #(
  parameter int MAX_JOBS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cmd_valid,
  output logic                             cmd_ready,
  input  wire rrs_pkg::cmd_t               cmd,
  input  wire logic [rrs_pkg::QUANT_W-1:0] quantum,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output rrs_pkg::status_t                 status,
  output logic [rrs_pkg::ID_W-1:0]         slice_job,
  output logic [rrs_pkg::TIME_W-1:0]       slice_start,
  output logic [rrs_pkg::TIME_W-1:0]       slice_finish,
  output logic                             job_done,
  output logic [rrs_pkg::TIME_W-1:0]       response_time,
  output logic [rrs_pkg::TIME_W-1:0]       turnaround_time,
  output logic [rrs_pkg::TIME_W-1:0]       waiting_time
);
  import rrs_pkg::*;

  localparam int PW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CW = $clog2(MAX_JOBS + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(MAX_JOBS - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_JOBS);

  // Ready queue memory and its registered read data.
  entry_t mem [MAX_JOBS];
  entry_t rd_data;
  logic   mem_we;
  logic   mem_re;
  entry_t mem_wdata;

  // Control state.
  state_t        state, state_next;
  logic [PW-1:0] head, head_next;
  logic [PW-1:0] tail, tail_next;
  logic [CW-1:0] count, count_next;
  logic [TIME_W-1:0] cur_time, cur_time_next;

  // Slice registers between the execute and response steps.
  logic [ID_W-1:0]    ex_job, ex_job_next;
  logic [TIME_W-1:0]  ex_start, ex_start_next;
  logic [TIME_W-1:0]  ex_finish, ex_finish_next;
  logic [TIME_W-1:0]  ex_first, ex_first_next;
  logic [BURST_W-1:0] ex_burst, ex_burst_next;
  logic               ex_done, ex_done_next;

  // Result register next values.
  logic              out_valid_next;
  logic              out_load;
  status_t           status_next;
  logic [ID_W-1:0]   slice_job_next;
  logic [TIME_W-1:0] slice_start_next;
  logic [TIME_W-1:0] slice_finish_next;
  logic              job_done_next;
  logic [TIME_W-1:0] response_next;
  logic [TIME_W-1:0] turnaround_next;
  logic [TIME_W-1:0] waiting_next;

  // Slice arithmetic.
  logic [QUANT_W-1:0] q_eff;
  logic               requeue;
  logic [BURST_W-1:0] run;
  logic [TIME_W:0]    finish_sum;
  logic [TIME_W-1:0]  finish_sat;
  logic [TIME_W-1:0]  burst_ext;

  // Memory: one write port at the tail, one registered read at the head.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[head];
    end
  end

  // Slice length, finish time and whether the job goes back to the queue.
  always_comb begin
    q_eff      = (quantum == '0) ? QUANT_W'(1) : quantum;
    requeue    = (rd_data.remaining > q_eff);
    run        = requeue ? q_eff : rd_data.remaining;
    finish_sum = {1'b0, cur_time} + (TIME_W + 1)'(run);
    finish_sat = finish_sum[TIME_W] ? TIME_MAX : finish_sum[TIME_W-1:0];
    burst_ext  = TIME_W'(ex_burst);
  end

  // Sequencer: next state, queue updates and result formation.
  always_comb begin
    state_next     = state;
    head_next      = head;
    tail_next      = tail;
    count_next     = count;
    cur_time_next  = cur_time;
    cmd_ready      = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_wdata      = '0;
    ex_job_next    = ex_job;
    ex_start_next  = ex_start;
    ex_finish_next = ex_finish;
    ex_first_next  = ex_first;
    ex_burst_next  = ex_burst;
    ex_done_next   = ex_done;

    out_load          = 1'b0;
    status_next       = STATUS_SLICE;
    slice_job_next    = '0;
    slice_start_next  = '0;
    slice_finish_next = '0;
    job_done_next     = 1'b0;
    response_next     = '0;
    turnaround_next   = '0;
    waiting_next      = '0;

    unique case (state)
      ST_IDLE: begin
        // A command starts only when the result register is free.
        if (cmd_valid && (!out_valid || out_ready)) begin
          cmd_ready = 1'b1;
          unique case (cmd.op)
            OP_ADD: begin
              out_load = 1'b1;
              if (count == FULL_CNT) begin
                status_next = STATUS_FULL;
              end else begin
                status_next           = STATUS_ACCEPTED;
                mem_we                = 1'b1;
                mem_wdata.job         = cmd.job_id;
                mem_wdata.remaining   = cmd.burst;
                mem_wdata.burst       = cmd.burst;
                mem_wdata.first_start = '0;
                mem_wdata.started     = 1'b0;
                tail_next  = (tail == LAST_PTR) ? '0 : tail + PW'(1);
                count_next = count + CW'(1);
              end
            end
            OP_DISPATCH: begin
              if (count == '0) begin
                out_load    = 1'b1;
                status_next = STATUS_EMPTY;
              end else begin
                mem_re     = 1'b1;
                head_next  = (head == LAST_PTR) ? '0 : head + PW'(1);
                count_next = count - CW'(1);
                state_next = ST_EXEC;
              end
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_EXEC: begin
        // Run the slice and put unfinished work back at the tail.
        cur_time_next  = finish_sat;
        ex_job_next    = rd_data.job;
        ex_start_next  = cur_time;
        ex_finish_next = finish_sat;
        ex_first_next  = rd_data.started ? rd_data.first_start : cur_time;
        ex_burst_next  = rd_data.burst;
        ex_done_next   = !requeue;
        if (requeue) begin
          mem_we                = 1'b1;
          mem_wdata.job         = rd_data.job;
          mem_wdata.remaining   = rd_data.remaining - q_eff;
          mem_wdata.burst       = rd_data.burst;
          mem_wdata.first_start = rd_data.started ? rd_data.first_start : cur_time;
          mem_wdata.started     = 1'b1;
          tail_next  = (tail == LAST_PTR) ? '0 : tail + PW'(1);
          count_next = count + CW'(1);
        end
        state_next = ST_RESP;
      end
      ST_RESP: begin
        // The result register was drained when the dispatch started.
        out_load          = 1'b1;
        status_next       = STATUS_SLICE;
        slice_job_next    = ex_job;
        slice_start_next  = ex_start;
        slice_finish_next = ex_finish;
        job_done_next     = ex_done;
        if (ex_done) begin
          response_next   = ex_first;
          turnaround_next = ex_finish;
          waiting_next    = (ex_finish >= burst_ext) ? ex_finish - burst_ext : '0;
        end
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    out_valid_next = out_load || (out_valid && !out_ready);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      cur_time  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      count     <= count_next;
      cur_time  <= cur_time_next;
      out_valid <= out_valid_next;
    end
  end

  // Slice and result payload registers.
  always_ff @(posedge clk) begin
    ex_job    <= ex_job_next;
    ex_start  <= ex_start_next;
    ex_finish <= ex_finish_next;
    ex_first  <= ex_first_next;
    ex_burst  <= ex_burst_next;
    ex_done   <= ex_done_next;
    if (out_load) begin
      status          <= status_next;
      slice_job       <= slice_job_next;
      slice_start     <= slice_start_next;
      slice_finish    <= slice_finish_next;
      job_done        <= job_done_next;
      response_time   <= response_next;
      turnaround_time <= turnaround_next;
      waiting_time    <= waiting_next;
    end
  end

endmodule : rrs_back
`default_nettype wire

[sim/rrs_slice_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_slice_checker: result checker for the round-robin scheduler
// Watches the quantum port and both channels of the scheduler, keeps its own
// copy of the ready queue and the scheduling clock, works out the result of
// every input transfer and compares each result transfer, field by field,
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module rrs_slice_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [rrs_pkg::QUANT_W-1:0] cfg_data,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        func,
  input  logic [rrs_pkg::ID_W-1:0]    job_id,
  input  logic [rrs_pkg::BURST_W-1:0] burst_time,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  rrs_pkg::status_t            status,
  input  logic [rrs_pkg::ID_W-1:0]    slice_job,
  input  logic [rrs_pkg::TIME_W-1:0]  slice_start,
  input  logic [rrs_pkg::TIME_W-1:0]  slice_finish,
  input  logic                        job_done,
  input  logic [rrs_pkg::TIME_W-1:0]  response_time,
  input  logic [rrs_pkg::TIME_W-1:0]  turnaround_time,
  input  logic [rrs_pkg::TIME_W-1:0]  waiting_time,
  output int                          error_count,
  output int                          pending_count
);

  import rrs_pkg::*;

  localparam logic [QUANT_W-1:0] QUANTUM_RESET = 16'd4;
  // Beyond this many mismatches only the count goes on rising.
  localparam int REPORT_CAP = 100;

  typedef struct packed {
    status_t             status;
    logic [ID_W-1:0]     job;
    logic [TIME_W-1:0]   start;
    logic [TIME_W-1:0]   stop;
    logic                done;
    logic [TIME_W-1:0]   response;
    logic [TIME_W-1:0]   turnaround;
    logic [TIME_W-1:0]   waiting;
  } slice_report_t;

  // Mirror of the scheduler state.
  entry_t             ready_q [QUEUE_DEPTH];
  int                 head_idx;
  int                 tail_idx;
  int                 job_count;
  logic [TIME_W-1:0]  sim_clock;
  logic [QUANT_W-1:0] quantum_reg;

  slice_report_t      expected_reports [$];
  int                 mismatch_total = 0;

  initial begin
    error_count   = 0;
    pending_count = 0;
  end

  function automatic void push_job(entry_t e);
    ready_q[tail_idx] = e;
    tail_idx = (tail_idx + 1) % QUEUE_DEPTH;
    job_count++;
  endfunction

  // Applies one command to the mirror state and returns the result it gives.
  function automatic slice_report_t schedule_item(op_t op, logic [ID_W-1:0] id,
                                                  logic [BURST_W-1:0] burst);
    slice_report_t    r;
    entry_t           e;
    logic [QUANT_W:0] grant;
    logic [BURST_W-1:0] run_len;
    logic [TIME_W:0]  sum;
    r = '0;
    e = '0;
    if (op == OP_ADD) begin
      if (job_count >= QUEUE_DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        e.job       = id;
        e.remaining = burst;
        e.burst     = burst;
        push_job(e);
        r.status = STATUS_ACCEPTED;
      end
      return r;
    end
    if (job_count == 0) begin
      r.status = STATUS_EMPTY;
      return r;
    end
    e = ready_q[head_idx];
    head_idx = (head_idx + 1) % QUEUE_DEPTH;
    job_count--;

    // A quantum of zero grants one unit; the clock stops at its maximum.
    grant   = (quantum_reg == '0) ? (QUANT_W + 1)'(1) : {1'b0, quantum_reg};
    run_len = (e.remaining > grant[BURST_W-1:0]) ? grant[BURST_W-1:0] : e.remaining;
    sum     = {1'b0, sim_clock} + (TIME_W + 1)'(run_len);
    r.status = STATUS_SLICE;
    r.job    = e.job;
    r.start  = sim_clock;
    r.stop   = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    sim_clock = r.stop;
    if (!e.started) begin
      e.first_start = r.start;
      e.started     = 1'b1;
    end

    // Unfinished jobs go back to the tail with the full grant taken off.
    if (e.remaining > grant[BURST_W-1:0]) begin
      e.remaining = e.remaining - grant[BURST_W-1:0];
      push_job(e);
    end else begin
      r.done       = 1'b1;
      r.response   = e.first_start;
      r.turnaround = r.stop;
      r.waiting    = (r.stop >= TIME_W'(e.burst)) ? r.stop - TIME_W'(e.burst) : '0;
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_total++;
      if (mismatch_total <= REPORT_CAP)
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endtask

  // Results are taken before commands, so an unexpected result is never
  // hidden by a command accepted on the same edge.
  always @(posedge clk) begin
    slice_report_t want;
    if (rst) begin
      head_idx    = 0;
      tail_idx    = 0;
      job_count   = 0;
      sim_clock   = '0;
      quantum_reg = QUANTUM_RESET;
      expected_reports.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          mismatch_total++;
          $error("result transfer with no command outstanding");
        end else begin
          want = expected_reports.pop_front();
          check_field("status", 32'(want.status), 32'(status));
          check_field("slice_job", 32'(want.job), 32'(slice_job));
          check_field("slice_start", 32'(want.start), 32'(slice_start));
          check_field("slice_finish", 32'(want.stop), 32'(slice_finish));
          check_field("job_done", 32'(want.done), 32'(job_done));
          check_field("response_time", 32'(want.response), 32'(response_time));
          check_field("turnaround_time", 32'(want.turnaround), 32'(turnaround_time));
          check_field("waiting_time", 32'(want.waiting), 32'(waiting_time));
        end
      end
      if (cfg_write)
        quantum_reg = cfg_data;
      if (in_valid && in_ready)
        expected_reports.push_back(schedule_item(op_t'(func), job_id, burst_time));
    end
    pending_count <= expected_reports.size();
    error_count   <= mismatch_total;
  end

endmodule : rrs_slice_checker

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the round-robin time-slice scheduler
// Drives add and dispatch commands under several quantum settings, with
// random gaps on the command side and random stalls on the result side, and
// leaves prediction and comparison to the slice checker beside the block.
// The run ends by pushing the scheduling clock into saturation.
// ----------------------------------------------------------------------------
module tb_top;

  import rrs_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SEG_LEN     = 37;
  localparam int SEGS        = 6;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_write;
  logic [QUANT_W-1:0]  cfg_data;
  logic                in_valid;
  logic                in_ready;
  logic                func;
  logic [ID_W-1:0]     job_id;
  logic [BURST_W-1:0]  burst_time;
  logic                out_valid;
  logic                out_ready;
  status_t             status;
  logic [ID_W-1:0]     slice_job;
  logic [TIME_W-1:0]   slice_start;
  logic [TIME_W-1:0]   slice_finish;
  logic                job_done;
  logic [TIME_W-1:0]   response_time;
  logic [TIME_W-1:0]   turnaround_time;
  logic [TIME_W-1:0]   waiting_time;

  int error_count;
  int pending_count;
  int cycle_count = 0;
  int add_count = 0;
  int dispatch_count = 0;
  int quantum_writes = 0;
  bit tx_gaps_on = 1'b1;
  bit rx_stall_on = 1'b1;

  round_robin_time_slice_scheduler #(.MAX_JOBS(QUEUE_DEPTH)) u_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .job_id(job_id), .burst_time(burst_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .slice_job(slice_job),
    .slice_start(slice_start), .slice_finish(slice_finish),
    .job_done(job_done), .response_time(response_time),
    .turnaround_time(turnaround_time), .waiting_time(waiting_time)
  );

  rrs_slice_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_checker (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .job_id(job_id), .burst_time(burst_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .slice_job(slice_job),
    .slice_start(slice_start), .slice_finish(slice_finish),
    .job_done(job_done), .response_time(response_time),
    .turnaround_time(turnaround_time), .waiting_time(waiting_time),
    .error_count(error_count), .pending_count(pending_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog: a hung handshake ends the run here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_top failed");
    $finish;
  end

  // Result side: open stretches broken by stalls, mostly short.
  initial begin : result_sink
    int unsigned open_len;
    int unsigned hold_len;
    forever begin
      open_len = $urandom_range(1, 12);
      hold_len = 0;
      if (rx_stall_on)
        hold_len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      out_ready <= 1'b1;
      repeat (open_len) @(posedge clk);
      if (hold_len != 0) begin
        out_ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
      end
    end
  end

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!tx_gaps_on || r < 60)
      return 0;
    return (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0)
      return '0;
    if (r == 1)
      return '1;
    return ID_W'($urandom_range(0, 65535));
  endfunction

  // Mostly short jobs, so that the clock saturates only in the last phase.
  function automatic logic [BURST_W-1:0] pick_burst();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3)
      return '0;
    if (r < 4)
      return BURST_W'($urandom_range(0, 65535));
    if (r < 10)
      return BURST_W'($urandom_range(13, 255));
    return BURST_W'($urandom_range(1, 12));
  endfunction

  // Offers one command and returns at the edge where it is transferred.
  // Valid stays high after a transfer so that a following command can go
  // out back to back.
  task automatic offer_cmd(op_t op, logic [ID_W-1:0] id, logic [BURST_W-1:0] burst);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    func       <= op;
    job_id     <= id;
    burst_time <= burst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == OP_ADD)
      add_count++;
    else
      dispatch_count++;
  endtask

  task automatic drain_outstanding();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_quantum(logic [QUANT_W-1:0] q);
    drain_outstanding();
    cfg_write <= 1'b1;
    cfg_data  <= q;
    @(posedge clk);
    cfg_write <= 1'b0;
    quantum_writes++;
  endtask

  // A phase of random traffic: segments lean towards adds, dispatches or
  // neither, with idling switched on or off per segment.
  task automatic random_phase(logic [QUANT_W-1:0] q);
    int unsigned add_pct;
    op_t         op;
    write_quantum(q);
    for (int seg = 0; seg < SEGS; seg++) begin
      case ($urandom_range(0, 3))
        0: add_pct = 75;
        1: add_pct = 25;
        default: add_pct = 50;
      endcase
      tx_gaps_on  = ($urandom_range(0, 3) != 0);
      rx_stall_on = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < SEG_LEN; k++) begin
        op = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_DISPATCH;
        offer_cmd(op, pick_id(), pick_burst());
      end
    end
  endtask

  initial begin
    rst        <= 1'b1;
    cfg_write  <= 1'b0;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    func       <= OP_ADD;
    job_id     <= '0;
    burst_time <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed start: empty queue, zero-length job, extreme ids, a job
    // needing several slices, then filling the queue past its depth.
    write_quantum(16'd3);
    offer_cmd(OP_DISPATCH, 16'h1234, 16'h4321);
    offer_cmd(OP_ADD, 16'h0000, 16'd0);
    offer_cmd(OP_ADD, 16'hFFFF, 16'd1);
    offer_cmd(OP_ADD, 16'hA5A5, 16'd7);
    repeat (3) offer_cmd(OP_DISPATCH, '0, '0);
    offer_cmd(OP_ADD, 16'h5A5A, 16'd3);
    repeat (15) offer_cmd(OP_ADD, pick_id(), BURST_W'($urandom_range(1, 6)));
    repeat (2) offer_cmd(OP_DISPATCH, '1, '1);

    // Random traffic over a spread of quantum settings.
    random_phase(16'd1);
    random_phase(QUANT_W'($urandom_range(2, 8)));
    random_phase(16'd0);
    random_phase(QUANT_W'($urandom_range(9, 300)));
    random_phase(16'd4);

    // Long jobs under large quanta drive the clock into saturation.
    tx_gaps_on  = 1'b1;
    rx_stall_on = 1'b1;
    write_quantum(16'hFFFF);
    for (int k = 0; k < 16; k++) begin
      offer_cmd(OP_ADD, pick_id(), 16'hFFFF);
      repeat (2) offer_cmd(OP_DISPATCH, pick_id(), pick_burst());
    end
    write_quantum(16'd30000);
    repeat (16) offer_cmd(OP_ADD, pick_id(), BURST_W'($urandom_range(40000, 65535)));
    repeat (64) offer_cmd(OP_DISPATCH, pick_id(), pick_burst());

    drain_outstanding();
    repeat (16) @(posedge clk);

    $display("Run covered %0d adds and %0d dispatches under %0d quantum settings,",
             add_count, dispatch_count, quantum_writes);
    $display("including full and empty queues, zero quantum and clock saturation.");
    if (error_count == 0 && pending_count == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule : tb_top

[round_robin_time_slice_scheduler.f]
design/rrs_pkg.sv
design/rrs_front.sv
design/rrs_back.sv
design/round_robin_time_slice_scheduler.sv
sim/rrs_slice_checker.sv
sim/tb_top.sv
